/* rtl/core/rover_drive_mode_controller_core_defines.svh */
// Assertion macros used by the rover drive controller result sequencer.
`ifndef ROVER_DRIVE_MODE_CONTROLLER_CORE_DEFINES_SVH
`define ROVER_DRIVE_MODE_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RDMC_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rdmc: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RDMC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rdmc: assertion failed");

`endif

/* rtl/core/rdmc_pkg.sv */
// Types and constants of the rover drive mode controller.
`default_nettype none

package rdmc_pkg;

    localparam int US_W   = 15;
    localparam int PWM_W  = 8;
    localparam int HOLD_W = 9;
    localparam int DIST_W = 8;
    localparam int LINE_W = 5;
    localparam int CFG_W  = 16;

    // Radio thresholds (us)
    localparam logic [US_W-1:0] STICK_MIN_US    = 15'd930;
    localparam logic [US_W-1:0] STICK_MAX_US    = 15'd2070;
    localparam logic [US_W-1:0] MODE_AUTO_US    = 15'd1300;
    localparam logic [US_W-1:0] MODE_MANUAL_US  = 15'd1700;
    localparam logic [US_W-1:0] MODE_MIN_US     = 15'd800;
    localparam logic [US_W-1:0] CENTER_US       = 15'd1500;
    localparam logic [US_W-1:0] DEAD_HI_US      = 15'd1550;
    localparam logic [US_W-1:0] DEAD_LO_US      = 15'd1450;
    localparam logic [US_W-1:0] STICK_FULL_REV  = 15'd1100;
    localparam logic [US_W-1:0] STICK_FULL_FWD  = 15'd1900;

    // Echo: cm = us / 58 via multiply by ceil(2^24/58), exact for us < 441505
    localparam logic [US_W-1:0] ECHO_MAX_US = 15'd23200;
    localparam int              RECIP_SHIFT = 24;
    localparam int              RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP_K  = 19'd289263;

    localparam logic [PWM_W-1:0]  PWM_FULL  = 8'd255;
    localparam logic [PWM_W-1:0]  PWM_BACK  = 8'd128;
    localparam logic [PWM_W-1:0]  PWM_OFF   = 8'd0;
    localparam logic [DIST_W-1:0] DIST_FAR  = 8'd255;
    localparam logic [HOLD_W-1:0] HOLD_LOOP = 9'd10;
    localparam logic [HOLD_W-1:0] HOLD_TURN = 9'd300;
    localparam logic [HOLD_W-1:0] HOLD_BACK = 9'd500;
    localparam logic [LINE_W-1:0] LINE_NONE = 5'h1F;

    typedef enum logic [1:0] {
        CFG_LOST_LIMIT   = 2'd0,
        CFG_STOP_DIST    = 2'd1,
        CFG_BACKOFF_DIST = 2'd2,
        CFG_TURN_DIST    = 2'd3
    } rdmc_cfg_idx_t;

    typedef struct packed {
        logic [US_W-1:0]   right_stick_us;
        logic [US_W-1:0]   left_stick_us;
        logic [US_W-1:0]   search_mode_us;
        logic [US_W-1:0]   mode_switch_us;
        logic [US_W-1:0]   echo_right_us;
        logic [US_W-1:0]   echo_left_us;
        logic [LINE_W-1:0] line_bits;
    } rdmc_sample_t;

    typedef struct packed {
        logic [PWM_W-1:0]  pwm_right;
        logic [PWM_W-1:0]  pwm_left;
        logic              dir_right;
        logic              dir_left;
        logic [HOLD_W-1:0] hold_ms;
        logic              last_of_run;
    } rdmc_result_t;

    typedef struct packed {
        logic [CFG_W-1:0]  lost_limit;
        logic [DIST_W-1:0] stop_distance_cm;
        logic [DIST_W-1:0] backoff_distance_cm;
        logic [DIST_W-1:0] turn_distance_cm;
    } rdmc_cfg_t;

    // Per-sample features that do not depend on controller state
    typedef struct packed {
        logic              failsafe;
        logic              manual;
        logic [PWM_W-1:0]  duty_r;
        logic [PWM_W-1:0]  duty_l;
        logic              dir_r;
        logic              dir_l;
        logic              auto_on;
        logic              ch5_lt_manual;
        logic              ch5_lt_auto;
        logic [LINE_W-1:0] line_bits;
        logic [DIST_W-1:0] dist_r;
        logic [DIST_W-1:0] dist_l;
    } rdmc_feat_t;

    // First result plus number of fixed turn results that follow it
    typedef struct packed {
        rdmc_result_t first;
        logic [1:0]   tail;
    } rdmc_plan_t;

endpackage

`default_nettype wire

/* rtl/core/rover_drive_mode_controller_core.sv */
// Top level of the rover drive mode controller: config registers and stage wiring.
//
// Usage:
//  - s_valid/s_ready/s_data carry one control-loop sample per transfer (stick,
//    mode and search pulse widths, two echo times, five line-sensor bits).
//  - m_valid/m_ready/m_data carry drive results; one sample yields one result,
//    two for a timed turn, three for a back-off. last_of_run marks the final one.
//  - cfg_wr_en/cfg_addr/cfg_wdata write one of the four tuning registers;
//    write them only while no sample is in flight.
//  - A sample's first result goes through the feature, then the output register.
//  - Throughput: one sample per cycle while each yields a single result and
//    m_ready is high; a sample with k results holds the output register for k
//    transfers.
//  - The input stage keeps accepting while a result waits in the output
//    register; when m_ready is low both stages fill and s_ready drops.
//  - Reset (aresetn low, synchronous) empties both stages, sets both
//    directions forward, clears the lost counter and last steer, and loads
//    the register defaults 100, 20, 40, 80.
`default_nettype none

module rover_drive_mode_controller_core #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire rdmc_pkg::rdmc_sample_t s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output rdmc_pkg::rdmc_result_t      m_data,
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_addr,
    input  wire logic [15:0]            cfg_wdata
);
    import rdmc_pkg::*;

    rdmc_cfg_t  cfg_reg, cfg_next;
    rdmc_feat_t feat;
    rdmc_plan_t plan;
    logic       feat_valid;
    logic       plan_ready;
    logic       plan_take;

    // Tuning registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (rdmc_cfg_idx_t'(cfg_addr))
                CFG_LOST_LIMIT:   cfg_next.lost_limit          = cfg_wdata;
                CFG_STOP_DIST:    cfg_next.stop_distance_cm    = cfg_wdata[DIST_W-1:0];
                CFG_BACKOFF_DIST: cfg_next.backoff_distance_cm = cfg_wdata[DIST_W-1:0];
                CFG_TURN_DIST:    cfg_next.turn_distance_cm    = cfg_wdata[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lost_limit          <= 16'd100;
            cfg_reg.stop_distance_cm    <= 8'd20;
            cfg_reg.backoff_distance_cm <= 8'd40;
            cfg_reg.turn_distance_cm    <= 8'd80;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // A decided sample moves into the output stage; state commits on this transfer
    assign plan_take = feat_valid && plan_ready;

    rdmc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .plan_take  (plan_take),
        .feat_valid (feat_valid),
        .feat       (feat)
    );

    rdmc_decide #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .feat      (feat),
        .plan_take (plan_take),
        .plan      (plan)
    );

    rdmc_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .plan       (plan),
        .plan_take  (plan_take),
        .plan_ready (plan_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

/* rtl/core/rdmc_front.sv */
// Input stage: stick, mode and echo decoding into a registered feature set.
`default_nettype none

module rdmc_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rdmc_pkg::rdmc_sample_t s_data,
    input  wire logic                  plan_take,
    output logic                       feat_valid,
    output rdmc_pkg::rdmc_feat_t       feat
);
    import rdmc_pkg::*;

    logic       valid_reg, valid_next;
    rdmc_feat_t feat_reg, feat_next;
    logic [PWM_W:0] stick_r, stick_l;

    // {dir, duty}
    function automatic logic [PWM_W:0] stick_duty(input logic [US_W-1:0] us);
        logic [US_W-1:0] diff;
        logic [PWM_W:0]  res;
        diff = '0;
        if (us <= STICK_FULL_REV) begin
            res = {1'b0, PWM_FULL};
        end else if (us >= STICK_FULL_FWD) begin
            res = {1'b1, PWM_FULL};
        end else if (us <= CENTER_US) begin
            diff = CENTER_US - us;
            res  = {1'b0, diff[PWM_W:1]};
        end else begin
            diff = us - CENTER_US;
            res  = {1'b1, diff[PWM_W:1]};
        end
        return res;
    endfunction

    function automatic logic [DIST_W-1:0] echo_cm(input logic [US_W-1:0] us);
        logic [US_W+RECIP_W-1:0] prod;
        logic [US_W+RECIP_W-RECIP_SHIFT-1:0] q;
        logic [DIST_W-1:0] res;
        prod = (US_W+RECIP_W)'(us) * (US_W+RECIP_W)'(RECIP_K);
        q    = prod[US_W+RECIP_W-1:RECIP_SHIFT];
        if (us == '0 || us >= ECHO_MAX_US) begin
            res = DIST_FAR;
        end else if (q > (US_W+RECIP_W-RECIP_SHIFT)'(DIST_FAR)) begin
            res = DIST_FAR;
        end else begin
            res = q[DIST_W-1:0];
        end
        return res;
    endfunction

    assign stick_r = stick_duty(s_data.right_stick_us);
    assign stick_l = stick_duty(s_data.left_stick_us);

    always_comb begin
        feat_next.failsafe =
            s_data.right_stick_us < STICK_MIN_US || s_data.right_stick_us > STICK_MAX_US ||
            s_data.left_stick_us < STICK_MIN_US  || s_data.left_stick_us > STICK_MAX_US  ||
            (s_data.mode_switch_us > MODE_AUTO_US && s_data.mode_switch_us < MODE_MANUAL_US) ||
            s_data.mode_switch_us < MODE_MIN_US;
        feat_next.manual =
            s_data.right_stick_us > DEAD_HI_US || s_data.right_stick_us < DEAD_LO_US ||
            s_data.left_stick_us > DEAD_HI_US  || s_data.left_stick_us < DEAD_LO_US;
        feat_next.duty_r        = stick_r[PWM_W-1:0];
        feat_next.duty_l        = stick_l[PWM_W-1:0];
        feat_next.dir_r         = stick_r[PWM_W];
        feat_next.dir_l         = stick_l[PWM_W];
        feat_next.auto_on       = s_data.mode_switch_us < MODE_AUTO_US;
        feat_next.ch5_lt_manual = s_data.search_mode_us < MODE_MANUAL_US;
        feat_next.ch5_lt_auto   = s_data.search_mode_us < MODE_AUTO_US;
        feat_next.line_bits     = s_data.line_bits;
        feat_next.dist_r        = echo_cm(s_data.echo_right_us);
        feat_next.dist_l        = echo_cm(s_data.echo_left_us);
    end

    assign s_ready = !valid_reg || plan_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (plan_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            feat_reg <= feat_next;
        end
    end

    assign feat_valid = valid_reg;
    assign feat       = feat_reg;

endmodule

`default_nettype wire

/* rtl/core/rdmc_decide.sv */
// Mode decision and controller state (directions, lost counter, last steer).
`default_nettype none

module rdmc_decide #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rdmc_pkg::rdmc_cfg_t  cfg,
    input  wire rdmc_pkg::rdmc_feat_t feat,
    input  wire logic                 plan_take,
    output rdmc_pkg::rdmc_plan_t      plan
);
    import rdmc_pkg::*;

    localparam int CMP_W = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;

    logic                    rdir_reg, rdir_next;
    logic                    ldir_reg, ldir_next;
    logic [COUNTER_BITS-1:0] lost_reg, lost_next;
    logic signed [2:0]       steer_reg, steer_next;

    logic              seen;
    logic signed [2:0] steer;
    logic              lost_below;
    logic              override_dirs;
    logic              near_stop, near_back, near_turn, all_far;

    always_comb begin
        seen  = feat.line_bits != LINE_NONE;
        steer = $signed({2'b00, feat.line_bits[0]}) + $signed({2'b00, feat.line_bits[1]})
              - $signed({2'b00, feat.line_bits[3]}) - $signed({2'b00, feat.line_bits[4]});
        lost_below = CMP_W'(lost_reg) < CMP_W'(cfg.lost_limit);
        near_stop  = feat.dist_r < cfg.stop_distance_cm ||
                     feat.dist_l < cfg.stop_distance_cm;
        near_back  = feat.dist_r < cfg.backoff_distance_cm ||
                     feat.dist_l < cfg.backoff_distance_cm;
        near_turn  = feat.dist_r < cfg.turn_distance_cm ||
                     feat.dist_l < cfg.turn_distance_cm;
        all_far    = feat.dist_r == DIST_FAR && feat.dist_l == DIST_FAR;

        rdir_next     = rdir_reg;
        ldir_next     = ldir_reg;
        lost_next     = lost_reg;
        steer_next    = steer_reg;
        override_dirs = 1'b0;

        plan.first.pwm_right   = PWM_OFF;
        plan.first.pwm_left    = PWM_OFF;
        plan.first.hold_ms     = HOLD_LOOP;
        plan.first.last_of_run = 1'b1;
        plan.tail              = 2'd0;

        if (feat.failsafe) begin
            // stop, keep directions
        end else if (feat.manual) begin
            rdir_next            = feat.dir_r;
            ldir_next            = feat.dir_l;
            plan.first.pwm_right = feat.duty_r;
            plan.first.pwm_left  = feat.duty_l;
        end else if (!feat.auto_on) begin
            // idle stop
        end else if (feat.ch5_lt_manual && seen) begin
            lost_next = '0;
            if (!near_stop) begin
                steer_next           = steer;
                plan.first.pwm_right = PWM_FULL;
                plan.first.pwm_left  = PWM_FULL;
                rdir_next            = 1'b1;
                ldir_next            = 1'b1;
                case (steer)
                    -3'sd2: begin
                        ldir_next = 1'b0;
                    end
                    -3'sd1: begin
                        plan.first.pwm_left = PWM_OFF;
                    end
                    3'sd1: begin
                        plan.first.pwm_right = PWM_OFF;
                    end
                    3'sd2: begin
                        rdir_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (feat.ch5_lt_manual && (feat.ch5_lt_auto || lost_below)) begin
            // search: spin toward the side the line was last seen on
            rdir_next            = steer_reg < 0;
            ldir_next            = !(steer_reg < 0);
            plan.first.pwm_right = PWM_FULL;
            plan.first.pwm_left  = PWM_FULL;
            if (lost_reg != '1) begin
                lost_next = lost_reg + 1'b1;
            end
        end else if (near_back) begin
            // reverse first, then two turn results
            override_dirs          = 1'b1;
            rdir_next              = 1'b0;
            ldir_next              = 1'b1;
            plan.first.pwm_right   = PWM_BACK;
            plan.first.pwm_left    = PWM_BACK;
            plan.first.hold_ms     = HOLD_BACK;
            plan.first.last_of_run = 1'b0;
            plan.tail              = 2'd2;
        end else if (all_far) begin
            rdir_next            = 1'b1;
            ldir_next            = 1'b1;
            plan.first.pwm_right = PWM_FULL;
            plan.first.pwm_left  = PWM_FULL;
        end else if (near_turn) begin
            rdir_next              = 1'b0;
            ldir_next              = 1'b1;
            plan.first.pwm_right   = PWM_FULL;
            plan.first.pwm_left    = PWM_FULL;
            plan.first.hold_ms     = HOLD_TURN;
            plan.first.last_of_run = 1'b0;
            plan.tail              = 2'd1;
        end else begin
            // roam: slow the side opposite the nearer obstacle (right side on a tie)
            rdir_next = 1'b1;
            ldir_next = 1'b1;
            if (feat.dist_r >= feat.dist_l) begin
                plan.first.pwm_right = feat.dist_l;
                plan.first.pwm_left  = PWM_FULL;
            end else begin
                plan.first.pwm_right = PWM_FULL;
                plan.first.pwm_left  = feat.dist_r;
            end
        end

        plan.first.dir_right = override_dirs ? 1'b0 : rdir_next;
        plan.first.dir_left  = override_dirs ? 1'b0 : ldir_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdir_reg  <= 1'b1;
            ldir_reg  <= 1'b1;
            lost_reg  <= '0;
            steer_reg <= 3'sd0;
        end else if (plan_take) begin
            rdir_reg  <= rdir_next;
            ldir_reg  <= ldir_next;
            lost_reg  <= lost_next;
            steer_reg <= steer_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rdmc_seq.sv */
// Result sequencer: output register and the fixed turn results of a maneuver.
`default_nettype none
`include "rover_drive_mode_controller_core_defines.svh"

module rdmc_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rdmc_pkg::rdmc_plan_t plan,
    input  wire logic                 plan_take,
    output logic                      plan_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rdmc_pkg::rdmc_result_t    m_data
);
    import rdmc_pkg::*;

    logic         valid_reg, valid_next;
    logic [1:0]   tail_reg, tail_next;
    rdmc_result_t out_reg, out_next;
    rdmc_result_t turn_res;

    assign plan_ready = (!valid_reg || m_ready) && tail_reg == 2'd0;

    always_comb begin
        turn_res.pwm_right   = PWM_FULL;
        turn_res.pwm_left    = PWM_FULL;
        turn_res.dir_right   = 1'b0;
        turn_res.dir_left    = 1'b1;
        turn_res.hold_ms     = (tail_reg == 2'd2) ? HOLD_TURN : HOLD_LOOP;
        turn_res.last_of_run = tail_reg == 2'd1;

        valid_next = valid_reg;
        tail_next  = tail_reg;
        out_next   = out_reg;
        if (plan_take) begin
            valid_next = 1'b1;
            tail_next  = plan.tail;
            out_next   = plan.first;
        end else if (valid_reg && m_ready) begin
            if (tail_reg != 2'd0) begin
                tail_next = tail_reg - 2'd1;
                out_next  = turn_res;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tail_reg  <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            tail_reg  <= tail_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = out_reg;

    `RDMC_ASSERT_IMPLY(a_tail_needs_valid, aclk, aresetn, tail_reg != 2'd0, valid_reg)
    `RDMC_ASSERT_IMPLY(a_open_run_has_tail, aclk, aresetn,
                       valid_reg && !out_reg.last_of_run, tail_reg != 2'd0)
    `RDMC_ASSERT_IMPLY(a_long_hold_not_last, aclk, aresetn,
                       valid_reg && out_reg.hold_ms != HOLD_LOOP, !out_reg.last_of_run)
    `RDMC_ASSERT_NEXT(a_run_continues, aclk, aresetn,
                      valid_reg && m_ready && !out_reg.last_of_run, valid_reg)

endmodule

`default_nettype wire
